>>> hw/rtl/pfcp_pkg.sv
package pfcp_pkg;

  localparam int NUM_FIELDS   = 18;
  localparam int HDR_BYTES    = 15;
  localparam int DECODE_BYTES = 13;

  localparam logic [4:0] FC_VERSION  = 5'd0;
  localparam logic [4:0] FC_MP       = 5'd1;
  localparam logic [4:0] FC_S        = 5'd2;
  localparam logic [4:0] FC_TYPE     = 5'd3;
  localparam logic [4:0] FC_MSGLEN   = 5'd4;
  localparam logic [4:0] FC_SEID     = 5'd5;
  localparam logic [4:0] FC_SEQ      = 5'd6;
  localparam logic [4:0] FC_NODETYPE = 5'd7;
  localparam logic [4:0] FC_NODEIP   = 5'd8;
  localparam logic [4:0] FC_V4       = 5'd9;
  localparam logic [4:0] FC_V6       = 5'd10;
  localparam logic [4:0] FC_FSEID    = 5'd11;
  localparam logic [4:0] FC_FSEIDIP  = 5'd12;
  localparam logic [4:0] FC_CAUSE    = 5'd13;
  localparam logic [4:0] FC_RECOVERY = 5'd14;
  localparam logic [4:0] FC_CPFEAT   = 5'd15;
  localparam logic [4:0] FC_UPFEAT   = 5'd16;
  localparam logic [4:0] FC_DONE     = 5'd17;

  localparam logic [2:0] REG_NODE_ID     = 3'd0;
  localparam logic [2:0] REG_FSEID       = 3'd1;
  localparam logic [2:0] REG_CAUSE       = 3'd2;
  localparam logic [2:0] REG_RECOVERY    = 3'd3;
  localparam logic [2:0] REG_CP_FEATURES = 3'd4;
  localparam logic [2:0] REG_UP_FEATURES = 3'd5;

  localparam logic [15:0] RST_NODE_ID     = 16'd60;
  localparam logic [15:0] RST_FSEID       = 16'd57;
  localparam logic [15:0] RST_CAUSE       = 16'd19;
  localparam logic [15:0] RST_RECOVERY    = 16'd96;
  localparam logic [15:0] RST_CP_FEATURES = 16'd89;
  localparam logic [15:0] RST_UP_FEATURES = 16'd43;

  localparam logic [3:0] HDR_LAST_SHORT = 4'd7;
  localparam logic [3:0] HDR_LAST_LONG  = 4'd15;

  localparam logic [15:0] LEN_MIN_ONE      = 16'd1;
  localparam logic [15:0] LEN_MIN_RECOVERY = 16'd4;
  localparam logic [15:0] LEN_MIN_NODEIP   = 16'd5;
  localparam logic [15:0] LEN_MIN_FSEID    = 16'd9;
  localparam logic [15:0] LEN_MIN_FSEIDIP  = 16'd13;

  typedef logic [NUM_FIELDS-1:0] field_mask_t;

  typedef struct packed {
    logic [15:0] node_id;
    logic [15:0] fseid;
    logic [15:0] cause;
    logic [15:0] recovery;
    logic [15:0] cp_features;
    logic [15:0] up_features;
  } codes_t;

  typedef struct packed {
    field_mask_t                 mask;
    logic [HDR_BYTES-1:0][7:0]   bytes;
    logic                        done_val;
  } entry_t;

  function automatic logic [63:0] field_value_of(logic [4:0] code, entry_t e);
    logic [63:0] v;
    v = '0;
    case (code)
      FC_VERSION:  v = {61'd0, e.bytes[0][7:5]};
      FC_MP:       v = {63'd0, e.bytes[0][4]};
      FC_S:        v = {63'd0, e.bytes[0][3]};
      FC_TYPE:     v = {56'd0, e.bytes[1]};
      FC_MSGLEN:   v = {48'd0, e.bytes[2], e.bytes[3]};
      FC_SEID:     v = {e.bytes[4], e.bytes[5], e.bytes[6], e.bytes[7],
                        e.bytes[8], e.bytes[9], e.bytes[10], e.bytes[11]};
      FC_SEQ: begin
        if (e.bytes[0][3]) begin
          v = {40'd0, e.bytes[12], e.bytes[13], e.bytes[14]};
        end else begin
          v = {40'd0, e.bytes[4], e.bytes[5], e.bytes[6]};
        end
      end
      FC_NODETYPE: v = {56'd0, e.bytes[0]};
      FC_NODEIP:   v = {32'd0, e.bytes[1], e.bytes[2], e.bytes[3], e.bytes[4]};
      FC_V4:       v = {63'd0, e.bytes[0][0]};
      FC_V6:       v = {63'd0, e.bytes[0][1]};
      FC_FSEID:    v = {e.bytes[1], e.bytes[2], e.bytes[3], e.bytes[4],
                        e.bytes[5], e.bytes[6], e.bytes[7], e.bytes[8]};
      FC_FSEIDIP:  v = {32'd0, e.bytes[9], e.bytes[10], e.bytes[11], e.bytes[12]};
      FC_CAUSE:    v = {56'd0, e.bytes[0]};
      FC_RECOVERY: v = {32'd0, e.bytes[0], e.bytes[1], e.bytes[2], e.bytes[3]};
      FC_CPFEAT:   v = {56'd0, e.bytes[0]};
      FC_UPFEAT:   v = {56'd0, e.bytes[0]};
      FC_DONE:     v = {63'd0, e.done_val};
      default:     v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/pfcp_front.sv
module pfcp_front #(
  parameter int VALUE_BYTES_KEPT = 13
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      data_byte,
  input  logic            end_of_buffer,
  input  pfcp_pkg::codes_t codes,
  input  logic            room,
  output logic            push,
  output pfcp_pkg::entry_t entry
);
  import pfcp_pkg::*;

  localparam int KW = $clog2(VALUE_BYTES_KEPT);

  typedef enum logic [2:0] {
    PH_HEADER   = 3'b001,
    PH_IE_HEAD  = 3'b010,
    PH_IE_VALUE = 3'b100
  } phase_t;

  phase_t      phase, phase_next, phase_step;
  logic [3:0]  hpos, hpos_next;
  logic [15:0] etype, etype_next;
  logic [15:0] elen, elen_next;
  logic [15:0] epos, epos_next;
  logic [7:0]  hdr [HDR_BYTES];
  logic [7:0]  vb [VALUE_BYTES_KEPT];
  logic        accept, hdr_we, vb_we, s_now;
  logic [16:0] epos_inc;
  logic [7:0]  vcur [DECODE_BYTES];
  field_mask_t mask;

  assign in_ready = room;
  assign accept   = in_valid && room;
  assign epos_inc = {1'b0, epos} + 17'd1;

  always_comb begin
    for (int i = 0; i < DECODE_BYTES; i++) begin
      vcur[i] = (epos == 16'(i)) ? data_byte : vb[i];
    end
  end

  always_comb begin
    phase_step = phase;
    hpos_next  = hpos;
    etype_next = etype;
    elen_next  = elen;
    epos_next  = epos;
    mask       = '0;
    hdr_we     = 1'b0;
    vb_we      = 1'b0;
    s_now      = (hpos == 4'd0) ? data_byte[3] : hdr[0][3];
    if (accept) begin
      case (phase)
        PH_HEADER: begin
          hdr_we    = (hpos != HDR_LAST_LONG);
          hpos_next = hpos + 4'd1;
          if ((s_now && hpos == HDR_LAST_LONG) || (!s_now && hpos == HDR_LAST_SHORT)) begin
            mask[FC_VERSION] = 1'b1;
            mask[FC_MP]      = 1'b1;
            mask[FC_S]       = 1'b1;
            mask[FC_TYPE]    = 1'b1;
            mask[FC_MSGLEN]  = 1'b1;
            mask[FC_SEID]    = s_now;
            mask[FC_SEQ]     = 1'b1;
            phase_step       = PH_IE_HEAD;
            epos_next        = '0;
          end
        end
        PH_IE_HEAD: begin
          case (epos[1:0])
            2'd0:    etype_next = {data_byte, 8'd0};
            2'd1:    etype_next = {etype[15:8], data_byte};
            2'd2:    elen_next  = {data_byte, 8'd0};
            default: elen_next  = {elen[15:8], data_byte};
          endcase
          epos_next = epos + 16'd1;
          if (epos[1:0] == 2'd3) begin
            epos_next = '0;
            if ({elen[15:8], data_byte} != 16'd0) begin
              phase_step = PH_IE_VALUE;
            end
          end
        end
        PH_IE_VALUE: begin
          vb_we     = (epos < 16'(VALUE_BYTES_KEPT));
          epos_next = epos_inc[15:0];
          if (epos_inc >= {1'b0, elen}) begin
            phase_step = PH_IE_HEAD;
            epos_next  = '0;
            if (etype == codes.node_id) begin
              if (elen >= LEN_MIN_ONE) begin
                mask[FC_NODETYPE] = 1'b1;
                mask[FC_NODEIP]   = (vcur[0] == 8'd0) && (elen >= LEN_MIN_NODEIP);
              end
            end else if (etype == codes.fseid) begin
              if (elen >= LEN_MIN_FSEID) begin
                mask[FC_V4]      = 1'b1;
                mask[FC_V6]      = 1'b1;
                mask[FC_FSEID]   = 1'b1;
                mask[FC_FSEIDIP] = vcur[0][0] && (elen >= LEN_MIN_FSEIDIP);
              end
            end else if (etype == codes.cause) begin
              mask[FC_CAUSE] = (elen >= LEN_MIN_ONE);
            end else if (etype == codes.recovery) begin
              mask[FC_RECOVERY] = (elen >= LEN_MIN_RECOVERY);
            end else if (etype == codes.cp_features) begin
              mask[FC_CPFEAT] = (elen >= LEN_MIN_ONE);
            end else if (etype == codes.up_features) begin
              mask[FC_UPFEAT] = (elen >= LEN_MIN_ONE);
            end
          end
        end
        default: phase_step = PH_HEADER;
      endcase
    end
    phase_next     = phase_step;
    entry.done_val = (phase_step == PH_HEADER);
    if (accept && end_of_buffer) begin
      mask[FC_DONE] = 1'b1;
      phase_next    = PH_HEADER;
      hpos_next     = '0;
      etype_next    = '0;
      elen_next     = '0;
      epos_next     = '0;
    end
    entry.mask = mask;
    for (int i = 0; i < HDR_BYTES; i++) begin
      if (phase == PH_HEADER) begin
        entry.bytes[i] = hdr[i];
      end else if (i < DECODE_BYTES) begin
        entry.bytes[i] = vcur[i];
      end else begin
        entry.bytes[i] = 8'd0;
      end
    end
    push = accept && (mask != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      hpos  <= '0;
      etype <= '0;
      elen  <= '0;
      epos  <= '0;
    end else begin
      phase <= phase_next;
      hpos  <= hpos_next;
      etype <= etype_next;
      elen  <= elen_next;
      epos  <= epos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr[hpos] <= data_byte;
    end
    if (vb_we) begin
      vb[epos[KW-1:0]] <= data_byte;
    end
  end

endmodule

>>> hw/rtl/pfcp_queue.sv
module pfcp_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pfcp_pkg::entry_t push_entry,
  output logic             room,
  input  logic             pop,
  output logic             head_valid,
  output pfcp_pkg::entry_t head
);
  import pfcp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign room       = (count != CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !do_pop) begin
        count <= count + CW'(1);
      end else if (!push && do_pop) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

>>> hw/rtl/pfcp_back.sv
module pfcp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  pfcp_pkg::entry_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [4:0]       field_code,
  output logic [63:0]      field_value,
  output logic             last_of_run
);
  import pfcp_pkg::*;

  field_mask_t rem, eff, pick, rest;
  logic        rem_valid, load, run_last;
  logic [4:0]  code;

  assign eff      = rem_valid ? rem : head.mask;
  assign pick     = eff & (~eff + field_mask_t'(1));
  assign rest     = eff & ~pick;
  assign run_last = (rest == '0);
  assign load     = head_valid && (!out_valid || out_ready);
  assign pop      = load && run_last;

  always_comb begin
    code = '0;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      if (pick[i]) begin
        code = code | 5'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rem_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      rem_valid <= !run_last;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem         <= rest;
      field_code  <= code;
      field_value <= field_value_of(code, head);
      last_of_run <= run_last;
    end
  end

endmodule

>>> hw/rtl/pfcp_tlv_message_parser_core.sv
// PFCP header and TLV information element parser. Bytes of a message buffer
// enter one per cycle on the data channel while in_ready is high, the final
// byte flagged by end_of_buffer. The front end accepts a byte in every cycle in
// which its queue of QUEUE_DEPTH result runs has room; a byte that completes
// the header, a recognized IE of enough length, or the buffer pushes one run
// into that queue. The back end sends one result per cycle from the queue head
// while out_ready is high, so a run (at most 8 for one byte) holds it and the
// front end keeps taking bytes until the queue fills. A result passes a queue
// slot and then the output register. IE type codes are written through the
// configuration channel, register index 0 to 5; other indexes are dropped.
module pfcp_tlv_message_parser_core #(
  parameter int VALUE_BYTES_KEPT = 13,
  parameter int QUEUE_DEPTH      = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  field_code,
  output logic [63:0] field_value,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import pfcp_pkg::*;

  codes_t codes;
  entry_t push_entry, head;
  logic   room, push, pop, head_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.node_id     <= RST_NODE_ID;
      codes.fseid       <= RST_FSEID;
      codes.cause       <= RST_CAUSE;
      codes.recovery    <= RST_RECOVERY;
      codes.cp_features <= RST_CP_FEATURES;
      codes.up_features <= RST_UP_FEATURES;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NODE_ID:     codes.node_id     <= cfg_data;
        REG_FSEID:       codes.fseid       <= cfg_data;
        REG_CAUSE:       codes.cause       <= cfg_data;
        REG_RECOVERY:    codes.recovery    <= cfg_data;
        REG_CP_FEATURES: codes.cp_features <= cfg_data;
        REG_UP_FEATURES: codes.up_features <= cfg_data;
        default: ;
      endcase
    end
  end

  pfcp_front #(
    .VALUE_BYTES_KEPT(VALUE_BYTES_KEPT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .end_of_buffer(end_of_buffer),
    .codes        (codes),
    .room         (room),
    .push         (push),
    .entry        (push_entry)
  );

  pfcp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .room      (room),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  pfcp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .field_code (field_code),
    .field_value(field_value),
    .last_of_run(last_of_run)
  );

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && field_code == FC_DONE |-> last_of_run)
    else $error("done result not last of its run");

  a_seid_then_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && field_code == FC_SEID |-> !last_of_run)
    else $error("seid result closed a run");

  a_v4_then_more: assert property (@(posedge clk) disable iff (rst)
    out_valid && field_code == FC_V4 |-> !last_of_run)
    else $error("v4 result closed a run");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> room)
    else $error("push into full queue");

endmodule

>>> tb/pfcp_field_monitor.sv
module pfcp_field_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [4:0]  field_code,
  input  logic [63:0] field_value,
  input  logic        last_of_run,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pfcp_pkg::*;

  localparam logic [1:0] PH_HEADER   = 2'd0;
  localparam logic [1:0] PH_IE_HEAD  = 2'd1;
  localparam logic [1:0] PH_IE_VALUE = 2'd2;

  typedef struct packed {
    logic [4:0]  code;
    logic [63:0] value;
    logic        last;
  } field_t;

  codes_t      codes;
  logic [1:0]  phase;
  logic [4:0]  hdr_pos;
  logic [7:0]  hdr [16];
  logic [15:0] ie_type;
  logic [15:0] ie_len;
  logic [15:0] ie_pos;
  logic [7:0]  val [DECODE_BYTES];
  field_t      expected_fields[$];
  field_t      run[$];
  int          err_cnt = 0;

  function automatic void add(input logic [4:0] code, input logic [63:0] value);
    field_t f;
    f.code  = code;
    f.value = value;
    f.last  = 1'b0;
    run.push_back(f);
  endfunction

  // work out the results caused by one accepted byte and queue them
  function automatic void predict_fields(input logic [7:0] data, input logic eob);
    logic [4:0] need;
    run.delete();
    if (phase == PH_HEADER) begin
      if (hdr_pos < 5'd16) hdr[hdr_pos[3:0]] = data;
      hdr_pos = hdr_pos + 5'd1;
      need = hdr[0][3] ? 5'd16 : 5'd8;
      if (hdr_pos >= need) begin
        add(FC_VERSION, {61'd0, hdr[0][7:5]});
        add(FC_MP, {63'd0, hdr[0][4]});
        add(FC_S, {63'd0, hdr[0][3]});
        add(FC_TYPE, {56'd0, hdr[1]});
        add(FC_MSGLEN, {48'd0, hdr[2], hdr[3]});
        if (hdr[0][3]) begin
          add(FC_SEID, {hdr[4], hdr[5], hdr[6], hdr[7], hdr[8], hdr[9], hdr[10], hdr[11]});
          add(FC_SEQ, {40'd0, hdr[12], hdr[13], hdr[14]});
        end else begin
          add(FC_SEQ, {40'd0, hdr[4], hdr[5], hdr[6]});
        end
        phase  = PH_IE_HEAD;
        ie_pos = '0;
      end
    end else if (phase == PH_IE_HEAD) begin
      case (ie_pos)
        16'd0: ie_type = {data, 8'h00};
        16'd1: ie_type[7:0] = data;
        16'd2: ie_len = {data, 8'h00};
        default: ie_len[7:0] = data;
      endcase
      ie_pos = ie_pos + 16'd1;
      if (ie_pos >= 16'd4) begin
        ie_pos = '0;
        if (ie_len != 16'd0) phase = PH_IE_VALUE;
      end
    end else begin
      if (ie_pos < DECODE_BYTES) val[ie_pos[3:0]] = data;
      ie_pos = ie_pos + 16'd1;
      if (ie_pos >= ie_len) begin
        if (ie_type == codes.node_id) begin
          if (ie_len >= LEN_MIN_ONE) begin
            add(FC_NODETYPE, {56'd0, val[0]});
            if (val[0] == 8'd0 && ie_len >= LEN_MIN_NODEIP)
              add(FC_NODEIP, {32'd0, val[1], val[2], val[3], val[4]});
          end
        end else if (ie_type == codes.fseid) begin
          if (ie_len >= LEN_MIN_FSEID) begin
            add(FC_V4, {63'd0, val[0][0]});
            add(FC_V6, {63'd0, val[0][1]});
            add(FC_FSEID, {val[1], val[2], val[3], val[4], val[5], val[6], val[7], val[8]});
            if (val[0][0] && ie_len >= LEN_MIN_FSEIDIP)
              add(FC_FSEIDIP, {32'd0, val[9], val[10], val[11], val[12]});
          end
        end else if (ie_type == codes.cause) begin
          if (ie_len >= LEN_MIN_ONE) add(FC_CAUSE, {56'd0, val[0]});
        end else if (ie_type == codes.recovery) begin
          if (ie_len >= LEN_MIN_RECOVERY)
            add(FC_RECOVERY, {32'd0, val[0], val[1], val[2], val[3]});
        end else if (ie_type == codes.cp_features) begin
          if (ie_len >= LEN_MIN_ONE) add(FC_CPFEAT, {56'd0, val[0]});
        end else if (ie_type == codes.up_features) begin
          if (ie_len >= LEN_MIN_ONE) add(FC_UPFEAT, {56'd0, val[0]});
        end
        phase  = PH_IE_HEAD;
        ie_pos = '0;
      end
    end
    if (eob) begin
      add(FC_DONE, {63'd0, phase == PH_HEADER});
      phase   = PH_HEADER;
      hdr_pos = '0;
      ie_type = '0;
      ie_len  = '0;
      ie_pos  = '0;
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) expected_fields.push_back(run[i]);
  endfunction

  always @(posedge clk) begin
    field_t want;
    if (rst) begin
      codes   = '{RST_NODE_ID, RST_FSEID, RST_CAUSE, RST_RECOVERY,
                  RST_CP_FEATURES, RST_UP_FEATURES};
      phase   = PH_HEADER;
      hdr_pos = '0;
      ie_type = '0;
      ie_len  = '0;
      ie_pos  = '0;
      foreach (hdr[i]) hdr[i] = '0;
      foreach (val[i]) val[i] = '0;
      expected_fields.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_fields.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result code %0d value %h last %b",
                   $time, field_code, field_value, last_of_run);
        end else begin
          want = expected_fields.pop_front();
          if (field_code !== want.code || field_value !== want.value ||
              last_of_run !== want.last) begin
            err_cnt++;
            $display("%0t: expected code %0d value %h last %b, got code %0d value %h last %b",
                     $time, want.code, want.value, want.last,
                     field_code, field_value, last_of_run);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NODE_ID:     codes.node_id     = cfg_data;
          REG_FSEID:       codes.fseid       = cfg_data;
          REG_CAUSE:       codes.cause       = cfg_data;
          REG_RECOVERY:    codes.recovery    = cfg_data;
          REG_CP_FEATURES: codes.cp_features = cfg_data;
          REG_UP_FEATURES: codes.up_features = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_fields(data_byte, end_of_buffer);
    end
    errors  <= err_cnt;
    pending <= expected_fields.size();
  end

endmodule

>>> tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pfcp_pkg::*;

  localparam int         CYCLE_LIMIT   = 200000;
  localparam logic [2:0] REG_UNUSED_LO = 3'd6;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  field_code;
  logic [63:0] field_value;
  logic        last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int          errors;
  int          pending;

  int          send_idle = 32;
  int          recv_idle = 53;
  logic        hold_off = 1'b0;
  logic        hold_done = 1'b0;
  int          stall_left = 0;
  int          cycle_count = 0;
  int          sent = 0;
  logic [7:0]  msg_bytes[$];
  logic [15:0] code_now [6] = '{RST_NODE_ID, RST_FSEID, RST_CAUSE, RST_RECOVERY,
                                RST_CP_FEATURES, RST_UP_FEATURES};

  pfcp_tlv_message_parser_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .end_of_buffer(end_of_buffer),
    .out_valid(out_valid), .out_ready(out_ready),
    .field_code(field_code), .field_value(field_value), .last_of_run(last_of_run),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pfcp_field_monitor field_mon (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .end_of_buffer(end_of_buffer),
    .out_valid(out_valid), .out_ready(out_ready),
    .field_code(field_code), .field_value(field_value), .last_of_run(last_of_run),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** pfcp_tlv_message_parser_core: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_off && !hold_done) begin
      out_ready  <= 1'b0;
      stall_left <= 200;
      hold_done  <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic eob);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= data;
    end_of_buffer <= eob;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_buffer();
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    sent += msg_bytes.size();
    msg_bytes.delete();
  endtask

  // one buffer: mostly a well formed header and IEs, sometimes noise or cut short
  task automatic send_message();
    logic [7:0]  rb;
    logic [15:0] ie_code;
    int          len;
    int          fill;
    int          n_ie;
    int          sel;
    int          cut;
    logic        long_cut;
    long_cut = 1'b0;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 24)) begin
        rb = 8'($urandom);
        msg_bytes.push_back(rb);
      end
    end else begin
      rb = 8'($urandom);
      rb[3] = 1'($urandom_range(1));
      msg_bytes.push_back(rb);
      repeat (rb[3] ? 15 : 7) begin
        rb = 8'($urandom);
        msg_bytes.push_back(rb);
      end
      n_ie = $urandom_range(0, 4);
      while (n_ie > 0 && !long_cut) begin
        n_ie--;
        sel = $urandom_range(9);
        if (sel < 6) ie_code = code_now[sel];
        else if (sel == 8) ie_code = code_now[$urandom_range(5)];
        else ie_code = 16'($urandom);
        if (sel == 9) begin
          len      = $urandom_range(256, 65535);
          long_cut = 1'b1;
        end else if (sel == 8) begin
          len = 0;
        end else begin
          case ($urandom_range(5))
            0: len = $urandom_range(1, 3);
            1: len = $urandom_range(4, 5);
            2: len = $urandom_range(8, 9);
            3: len = $urandom_range(12, 13);
            4: len = $urandom_range(14, 22);
            default: len = $urandom_range(1, 13);
          endcase
        end
        msg_bytes.push_back(ie_code[15:8]);
        msg_bytes.push_back(ie_code[7:0]);
        msg_bytes.push_back(len[15:8]);
        msg_bytes.push_back(len[7:0]);
        fill = long_cut ? $urandom_range(0, 8) : len;
        for (int i = 0; i < fill; i++) begin
          rb = 8'($urandom);
          if (i == 0) begin
            case ($urandom_range(2))
              0: rb = 8'h00;
              1: rb = 8'($urandom_range(3));
              default: ;
            endcase
          end
          msg_bytes.push_back(rb);
        end
      end
      if (!long_cut && $urandom_range(99) < 12 && msg_bytes.size() > 1) begin
        cut = $urandom_range(1, msg_bytes.size() - 1);
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end
    end
    send_buffer();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_codes(input logic [15:0] node, input logic [15:0] fseid,
                            input logic [15:0] cause, input logic [15:0] recovery,
                            input logic [15:0] cp, input logic [15:0] up);
    logic [15:0] junk;
    write_reg(REG_NODE_ID, node);
    write_reg(REG_FSEID, fseid);
    write_reg(REG_CAUSE, cause);
    write_reg(REG_RECOVERY, recovery);
    write_reg(REG_CP_FEATURES, cp);
    write_reg(REG_UP_FEATURES, up);
    junk = 16'($urandom);
    write_reg(REG_UNUSED_LO, junk);
    junk = 16'($urandom);
    write_reg(REG_UNUSED_HI, junk);
    cfg_valid <= 1'b0;
    code_now[REG_NODE_ID]     = node;
    code_now[REG_FSEID]       = fseid;
    code_now[REG_CAUSE]       = cause;
    code_now[REG_RECOVERY]    = recovery;
    code_now[REG_CP_FEATURES] = cp;
    code_now[REG_UP_FEATURES] = up;
    @(posedge clk);
  endtask

  initial begin
    logic [15:0] code_a;
    logic [15:0] code_b;
    logic [15:0] code_c;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    msg_bytes = {8'hFF};
    send_buffer();
    msg_bytes = {8'hE8, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'h23, 8'h45, 8'h67,
                 8'h89, 8'hAB, 8'hCD, 8'hEF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    send_buffer();
    msg_bytes = {8'h30, 8'h05, 8'h00, 8'h09, 8'h00, 8'h00, 8'h01, 8'h00,
                 RST_CAUSE[15:8], RST_CAUSE[7:0], 8'h00, 8'h01, 8'h10};
    send_buffer();

    while (sent < 150) send_message();
    drain();

    load_codes(16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom));
    send_idle = 53;
    recv_idle <= 32;
    while (sent < 270) send_message();
    drain();

    // shared codes: the earlier register in the list has to win
    code_a = 16'($urandom);
    code_b = code_a ^ 16'h8001;
    code_c = code_a ^ 16'h0F0F;
    load_codes(code_a, code_b, code_a, code_b, code_c, code_c);
    send_idle = 0;
    recv_idle <= 0;
    hold_off  <= 1'b1;
    while (sent < 355) send_message();
    drain();

    if (errors == 0) begin
      $display("** pfcp_tlv_message_parser_core: PASSED **");
    end else begin
      $display("** pfcp_tlv_message_parser_core: FAILED **");
    end
    $finish;
  end

endmodule
